@@ hw/rtl/bsu_pkg.sv @@
package bsu_pkg;

  // Defaults for the top-level size parameters.
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int PALETTE_DEPTH  = 256;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM_UP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT       = 3'd4;

  // Pixel formats. Code 3 decodes as 24 bit.
  localparam logic [1:0] FMT_1BPP  = 2'd0;
  localparam logic [1:0] FMT_8BPP  = 2'd1;
  localparam logic [1:0] FMT_24BPP = 2'd2;

  // Item modes. Mode 3 is ignored.
  localparam logic [1:0] MODE_PALETTE = 2'd0;
  localparam logic [1:0] MODE_PIXEL   = 2'd1;
  localparam logic [1:0] MODE_START   = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam logic [23:0] COLOR_WHITE = 24'hffffff;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_address;
    logic [23:0] color;
    logic        last;
    logic        image_done;
  } out_item_t;

endpackage

@@ hw/rtl/bmp_scanline_unpacker.sv @@
// BMP scanline unpacker.
//
// The input channel carries one item per handshake: a palette write, one byte
// of the BMP pixel area (row padding included), or a request to start a new
// image. Pixel bytes come out as items on the output channel, each a 24-bit
// color (blue in 23:16, red in 7:0) with its image address after any row flip.
// The configuration channel is always ready. Registers must be written while
// idle (the block does not enforce it) and take effect on the next input item.
//
// A pixel item passes through the pending-job register and then the output
// register. Palette (8 bpp) and 24 bpp bytes are taken one per cycle while
// the receiver keeps up. A 1 bpp byte yields up to eight pixels through the
// single pixel emitter, one per cycle while the receiver keeps up; the next
// byte is accepted in the cycle the emitter hands out the final pixel.
//
// When the receiver stalls, the output register holds its item and the
// emitter and input back up behind it; nothing is dropped. Reset loads the
// register defaults and clears the row position and all pending items. The
// palette memory is not cleared and must be loaded before 8 bpp use.
module bmp_scanline_unpacker #(
  parameter int MAX_WIDTH  = bsu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bsu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bsu_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bsu_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bsu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bsu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Widths that follow from the size limits.
  localparam int DW = $clog2(MAX_WIDTH + 1);       // column and width
  localparam int HW = $clog2(MAX_HEIGHT + 1);      // row and height
  localparam int BW = $clog2(3 * MAX_WIDTH + 4);   // byte offset within a row
  localparam int PW = HW + DW;                     // row base product

  // Configuration registers.
  logic [1:0]  pixel_format;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic        bottom_up;
  logic        invert;

  // Position within the image.
  logic [BW-1:0] byte_in_row;
  logic [HW-1:0] row_count;
  logic [DW-1:0] column;
  logic [15:0]   partial_pixel;
  logic [1:0]    byte_phase;

  // Palette memory and its registered read data.
  logic [23:0] palette_mem [bsu_pkg::PALETTE_DEPTH];
  logic [23:0] pal_rdata;

  // Pending job: the pixels of one accepted byte, waiting for the emitter.
  logic          job_valid;
  logic          job_mono;
  logic          job_pal;
  logic [7:0]    job_bits;
  logic [3:0]    job_cnt;
  logic [23:0]   job_base;
  logic [DW-1:0] job_col;
  logic [23:0]   job_color;
  logic          job_done;

  // Decode of the accepted item.
  logic          in_fire;
  logic          is_pixel;
  logic          active;
  logic          in_row;
  logic          fmt_mono;
  logic          fmt_pal;
  logic [DW-1:0] w;
  logic [HW-1:0] h;
  logic [DW-1:0] remain;
  logic [3:0]    n;
  logic [BW-1:0] stride;
  logic [BW-1:0] w_ext;
  logic          row_end;
  logic [HW-1:0] out_row;
  logic [PW-1:0] row_prod;
  logic [15:0]   partial_next;
  logic [1:0]    phase_next;
  logic [7:0]    byte_eff;
  logic          job_load;
  logic          done_here;

  // Emitter and output register control.
  logic          out_free;
  logic          emit;
  logic          job_final;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign emit      = job_valid && out_free;
  assign job_final = emit && (job_cnt == 4'd1);
  assign in_ready  = !job_valid || job_final;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= bsu_pkg::FMT_1BPP;
      image_width  <= 13'd1;
      image_height <= 13'd1;
      bottom_up    <= 1'b1;
      invert       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsu_pkg::CFG_PIXEL_FORMAT: pixel_format <= cfg_data[1:0];
        bsu_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bsu_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        bsu_pkg::CFG_BOTTOM_UP:    bottom_up    <= cfg_data[0];
        bsu_pkg::CFG_INVERT:       invert       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Width and height: zero counts as one, and both saturate at the limits.
  always_comb begin
    if (image_width == 13'd0) begin
      w = DW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = DW'(MAX_WIDTH);
    end else begin
      w = DW'(image_width);
    end
    if (image_height == 13'd0) begin
      h = HW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(image_height);
    end
  end

  always_comb begin
    is_pixel = (in_item.mode == bsu_pkg::MODE_PIXEL);
    active   = (row_count < h);
    in_row   = (column < w);
    fmt_mono = (pixel_format == bsu_pkg::FMT_1BPP);
    fmt_pal  = (pixel_format == bsu_pkg::FMT_8BPP);
    byte_eff = invert ? ~in_item.data_byte : in_item.data_byte;
    remain   = w - column;

    // Rows are padded out to a whole number of 32-bit words.
    w_ext = BW'(w);
    if (fmt_mono) begin
      stride = ((w_ext + BW'(31)) >> 5) << 2;
    end else if (fmt_pal) begin
      stride = (w_ext + BW'(3)) & ~BW'(3);
    end else begin
      stride = (w_ext + w_ext + w_ext + BW'(3)) & ~BW'(3);
    end
    row_end = ((BW + 1)'(byte_in_row) + (BW + 1)'(1)) >= (BW + 1)'(stride);

    // Number of pixels this byte gives.
    n = 4'd0;
    if (in_row) begin
      if (fmt_mono) begin
        n = (remain >= DW'(8)) ? 4'd8 : remain[3:0];
      end else if (fmt_pal) begin
        n = 4'd1;
      end else if (byte_phase != 2'd0 && byte_phase != 2'd1) begin
        n = 4'd1;
      end
    end

    // 24-bit pixels arrive as blue, green, red.
    partial_next = partial_pixel;
    phase_next   = byte_phase;
    if (!fmt_mono && !fmt_pal && in_row) begin
      case (byte_phase)
        2'd0: begin
          partial_next = {in_item.data_byte, 8'h00};
          phase_next   = 2'd1;
        end
        2'd1: begin
          partial_next = {partial_pixel[15:8], in_item.data_byte};
          phase_next   = 2'd2;
        end
        default: begin
          partial_next = 16'h0000;
          phase_next   = 2'd0;
        end
      endcase
    end

    out_row   = bottom_up ? (h - HW'(1) - row_count) : row_count;
    row_prod  = PW'(out_row) * PW'(w);
    done_here = (row_count == h - HW'(1)) &&
                ((DW + 1)'(column) + (DW + 1)'(n) == (DW + 1)'(w));
    job_load  = in_fire && is_pixel && active && (n != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row   <= '0;
      row_count     <= '0;
      column        <= '0;
      partial_pixel <= '0;
      byte_phase    <= '0;
    end else if (in_fire) begin
      if (in_item.mode == bsu_pkg::MODE_START) begin
        byte_in_row   <= '0;
        row_count     <= '0;
        column        <= '0;
        partial_pixel <= '0;
        byte_phase    <= '0;
      end else if (is_pixel && active) begin
        if (row_end) begin
          byte_in_row   <= '0;
          column        <= '0;
          partial_pixel <= '0;
          byte_phase    <= '0;
          row_count     <= row_count + HW'(1);
        end else begin
          byte_in_row   <= byte_in_row + BW'(1);
          column        <= column + DW'(n);
          partial_pixel <= partial_next;
          byte_phase    <= phase_next;
        end
      end
    end
  end

  // Palette writes and reads never fall in the same cycle, since each comes
  // from its own accepted item. The read data is only refreshed by a pixel
  // byte, which is accepted once the previous job has gone out.
  always_ff @(posedge clk) begin
    if (in_fire && in_item.mode == bsu_pkg::MODE_PALETTE) begin
      palette_mem[in_item.palette_index] <=
        {in_item.palette_blue, in_item.palette_green, in_item.palette_red};
    end
    if (in_fire && is_pixel) begin
      pal_rdata <= palette_mem[byte_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (job_load) begin
      job_valid <= 1'b1;
    end else if (job_final) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_mono  <= fmt_mono;
      job_pal   <= fmt_pal;
      job_bits  <= byte_eff;
      job_cnt   <= n;
      job_base  <= 24'(row_prod);
      job_col   <= column;
      job_color <= {partial_pixel, in_item.data_byte};
      job_done  <= done_here;
    end else if (emit) begin
      job_bits <= {job_bits[6:0], 1'b0};
      job_cnt  <= job_cnt - 4'd1;
      job_col  <= job_col + DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.pixel_address <= job_base + 24'(job_col);
      if (job_mono) begin
        out_item.color <= job_bits[7] ? bsu_pkg::COLOR_WHITE : 24'h000000;
      end else if (job_pal) begin
        out_item.color <= pal_rdata;
      end else begin
        out_item.color <= job_color;
      end
      out_item.last       <= (job_cnt == 4'd1);
      out_item.image_done <= job_done && (job_cnt == 4'd1);
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the BMP scanline unpacker.
//
// A scoreboard object keeps its own copy of the configuration registers, the
// palette and the row position. Every item that the block accepts on the input
// channel is run through that copy, and the pixels it should produce are
// queued in order. Every pixel that leaves the block is compared field by field
// with the oldest queued pixel.
//
// Stimulus starts with a short directed sequence. It covers a 1x1 image with
// row padding and bytes past the final row, palette writes with extreme
// colors, inverted 8 bpp lookups, a bottom-up 24 bpp image and an ignored mode.
// After that, random images follow. Most of them are complete and well-formed.
// Some are cut short, some get a start item in the middle of a row, and some
// continue the previous image under new register values. Palette writes and
// ignored items are mixed in. Registers are rewritten only between images,
// once the block has drained.
module tb;

  // The register holds 2 bits; code 3 decodes as 24 bpp.
  localparam logic [1:0] FMT_ALIAS_24 = 2'd3;

  // The emitter hands out the pixels of one 1 bpp byte one at a time, and the output
  // register follows it. A byte that produces no pixel can still be in
  // flight after the last expected pixel has arrived, so each drain waits this
  // long.
  localparam int DRAIN_CYCLES = 12;
  // The length of the one long receiver stall that backs the block up.
  localparam int HOLD_CYCLES = 200;
  // The watchdog trips after this many cycles with no handshake on any channel.
  // The longest legitimate gap is the long stall plus a drain.
  localparam int QUIET_LIMIT = 2000;
  localparam int TARGET_ITEMS = 380;

  // Shadow model of the block. It is fed every accepted input item and every
  // register write, and it queues the pixels that those items should produce.
  class bmp_pixel_scoreboard;
    logic [1:0]  fmt;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    bit          flip;
    bit          inv;
    logic [23:0] palette [256];
    int unsigned byte_in_row;
    int unsigned row_count;
    int unsigned column;
    logic [15:0] partial;
    int unsigned byte_phase;
    bsu_pkg::out_item_t expected_pixels [$];
    int          errors;

    function new();
      fmt = bsu_pkg::FMT_1BPP;
      width_reg = 13'd1;
      height_reg = 13'd1;
      flip = 1'b1;
      inv = 1'b0;
      foreach (palette[i]) palette[i] = '0;
      errors = 0;
      clear_position();
    endfunction

    function void clear_position();
      byte_in_row = 0;
      row_count = 0;
      column = 0;
      partial = '0;
      byte_phase = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void write_reg(logic [bsu_pkg::CFG_INDEX_W-1:0] idx,
                            logic [bsu_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        bsu_pkg::CFG_PIXEL_FORMAT: fmt = value[1:0];
        bsu_pkg::CFG_IMAGE_WIDTH:  width_reg = value;
        bsu_pkg::CFG_IMAGE_HEIGHT: height_reg = value;
        bsu_pkg::CFG_BOTTOM_UP:    flip = value[0];
        bsu_pkg::CFG_INVERT:       inv = value[0];
        default: ;
      endcase
    endfunction

    // Queues one pixel at the current column and moves to the next column.
    function void add_pixel(int unsigned base, int unsigned h, int unsigned w,
                            logic [23:0] color);
      bsu_pkg::out_item_t px;
      px.pixel_address = 24'(base + column);
      px.color = color;
      px.last = 1'b0;
      px.image_done = (row_count == h - 1) && (column == w - 1);
      expected_pixels.push_back(px);
      column++;
    endfunction

    function void note_item(bsu_pkg::in_item_t it);
      int unsigned w;
      int unsigned h;
      int unsigned bpp;
      int unsigned stride;
      int unsigned out_row;
      int unsigned base;
      int          n;
      logic [7:0]  idx;
      n = 0;
      case (it.mode)
        bsu_pkg::MODE_PALETTE: begin
          palette[it.palette_index] =
            {it.palette_blue, it.palette_green, it.palette_red};
        end
        bsu_pkg::MODE_START: begin
          clear_position();
        end
        bsu_pkg::MODE_PIXEL: begin
          w = clamp_dim(width_reg, bsu_pkg::MAX_WIDTH_DEF);
          h = clamp_dim(height_reg, bsu_pkg::MAX_HEIGHT_DEF);
          // Bytes past the final row are dropped without a trace.
          if (row_count < h) begin
            bpp = (fmt == bsu_pkg::FMT_1BPP) ? 1 : ((fmt == bsu_pkg::FMT_8BPP) ? 8 : 24);
            stride = ((w * bpp + 31) / 32) * 4;
            out_row = flip ? (h - 1 - row_count) : row_count;
            base = out_row * w;
            // Once the column reaches the width, the rest of the row is padding.
            if (column < w) begin
              if (bpp == 1) begin
                for (int b = 7; b >= 0 && column < w; b--) begin
                  add_pixel(base, h, w, (it.data_byte[b] ^ inv) ?
                                        bsu_pkg::COLOR_WHITE : 24'h000000);
                  n++;
                end
              end else if (bpp == 8) begin
                idx = inv ? ~it.data_byte : it.data_byte;
                add_pixel(base, h, w, palette[idx]);
                n++;
              end else if (byte_phase == 0) begin
                partial = {it.data_byte, 8'h00};
                byte_phase = 1;
              end else if (byte_phase == 1) begin
                partial[7:0] = it.data_byte;
                byte_phase = 2;
              end else begin
                add_pixel(base, h, w, {partial, it.data_byte});
                n++;
                partial = '0;
                byte_phase = 0;
              end
            end
            if (n > 0) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
            byte_in_row++;
            if (byte_in_row >= stride) begin
              byte_in_row = 0;
              column = 0;
              partial = '0;
              byte_phase = 0;
              row_count++;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(bsu_pkg::out_item_t got);
      bsu_pkg::out_item_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel item: pixel_address %0h color %0h",
               got.pixel_address, got.color);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_address !== want.pixel_address) begin
        $error("pixel_address: expected %0h, got %0h", want.pixel_address, got.pixel_address);
        errors++;
      end
      if (got.color !== want.color) begin
        $error("color: expected %06h, got %06h", want.color, got.color);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
      if (got.image_done !== want.image_done) begin
        $error("image_done: expected %0d, got %0d", want.image_done, got.image_done);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  bsu_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bsu_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [bsu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bsu_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  bmp_pixel_scoreboard pixels = new();

  // Format and invert as last written. They keep 8 bpp bytes pointing at
  // palette entries that have actually been loaded.
  logic [1:0] cur_fmt = bsu_pkg::FMT_1BPP;
  bit         cur_inv = 1'b0;
  bit         pal_loaded [256];
  logic [7:0] loaded_idx [$];

  int  items_sent = 0;
  bit  steady_feed = 1'b0;   // no gaps between input items in this image
  bit  hold_request = 1'b0;  // asks the receiver for its one long stall
  int  quiet_cycles = 0;

  always #4 clk = ~clk;

  bmp_scanline_unpacker DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Observe all three channels at the edge where the handshakes complete. The
  // values seen here are the ones that were stable before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) pixels.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) pixels.note_item(in_item);
      if (out_valid && out_ready) pixels.check_pixel(out_item);
    end
  end

  // Watchdog. Any handshake restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver. It may stall before each pixel, except in calm stretches when it
  // takes every pixel at once. The one long stall lets the emitter and the input
  // back up behind a full output register.
  initial begin : receiver
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high afterward, so a back-to-back item never drops it for a step. Every
  // caller that pauses must lower valid itself.
  task automatic send_item(bsu_pkg::in_item_t it);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    if (it.mode != bsu_pkg::MODE_IGNORED) items_sent++;
  endtask

  // The fields that this mode does not use carry random values.
  function automatic bsu_pkg::in_item_t random_item(logic [1:0] mode);
    bsu_pkg::in_item_t it;
    it.mode = mode;
    it.data_byte = 8'($urandom);
    it.palette_index = 8'($urandom);
    it.palette_red = 8'($urandom);
    it.palette_green = 8'($urandom);
    it.palette_blue = 8'($urandom);
    return it;
  endfunction

  task automatic send_pixel(logic [7:0] b);
    bsu_pkg::in_item_t it;
    it = random_item(bsu_pkg::MODE_PIXEL);
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_palette(bsu_pkg::in_item_t it);
    if (!pal_loaded[it.palette_index]) begin
      pal_loaded[it.palette_index] = 1'b1;
      loaded_idx.push_back(it.palette_index);
    end
    send_item(it);
  endtask

  task automatic send_start();
    send_item(random_item(bsu_pkg::MODE_START));
  endtask

  // In 8 bpp mode only loaded palette entries may be looked up. Other formats
  // take any byte.
  function automatic logic [7:0] pick_byte();
    logic [7:0] idx;
    if (cur_fmt != bsu_pkg::FMT_8BPP) return 8'($urandom);
    idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
    return cur_inv ? ~idx : idx;
  endfunction

  // Lowers valid and waits until every expected pixel has arrived. Then it lets
  // trailing items that produce no pixel clear the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixels.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Valid stays high from one register write to the next.
  task automatic write_reg(logic [bsu_pkg::CFG_INDEX_W-1:0] idx,
                           logic [bsu_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [1:0] fmt, int w, int h, bit bu, bit inv);
    wait_idle();
    write_reg(bsu_pkg::CFG_PIXEL_FORMAT, bsu_pkg::CFG_DATA_W'(fmt));
    write_reg(bsu_pkg::CFG_IMAGE_WIDTH, bsu_pkg::CFG_DATA_W'(w));
    write_reg(bsu_pkg::CFG_IMAGE_HEIGHT, bsu_pkg::CFG_DATA_W'(h));
    write_reg(bsu_pkg::CFG_BOTTOM_UP, bsu_pkg::CFG_DATA_W'(bu));
    write_reg(bsu_pkg::CFG_INVERT, bsu_pkg::CFG_DATA_W'(inv));
    cfg_valid <= 1'b0;
    cur_fmt = fmt;
    cur_inv = inv;
  endtask

  // Sends pixel bytes with occasional palette writes and ignored items mixed
  // in. Once in a while a start item lands in the middle of the image.
  task automatic run_image(int n_bytes);
    for (int i = 0; i < n_bytes; i++) begin
      case ($urandom_range(0, 63))
        0, 1, 2: send_palette(random_item(bsu_pkg::MODE_PALETTE));
        3:       send_item(random_item(bsu_pkg::MODE_IGNORED));
        4:       send_start();
        default: ;
      endcase
      send_pixel(pick_byte());
    end
  endtask

  initial begin : stimulus
    bsu_pkg::in_item_t it;
    logic [1:0]  fmt;
    int          w;
    int          h;
    int          bpp;
    int          n_bytes;
    int          phase_no;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults give a 1x1 bottom-up image at 1 bpp. The first byte gives
    // one white pixel that also finishes the image. The next three bytes are
    // row padding, and the fifth byte lies past the final row.
    send_pixel(8'h80);
    send_pixel(8'h7f);
    send_pixel(8'hff);
    send_pixel(8'h00);
    send_pixel(8'h55);
    send_item(random_item(bsu_pkg::MODE_IGNORED));

    // Load palette entries with extreme colors at both ends of the index range.
    it = random_item(bsu_pkg::MODE_PALETTE);
    it.palette_index = 8'h00;
    it.palette_red = 8'hff;
    it.palette_green = 8'h00;
    it.palette_blue = 8'hff;
    send_palette(it);
    it.palette_index = 8'hff;
    it.palette_red = 8'h00;
    it.palette_green = 8'hff;
    it.palette_blue = 8'h00;
    send_palette(it);
    it = random_item(bsu_pkg::MODE_PALETTE);
    it.palette_index = 8'ha5;
    send_palette(it);

    // With invert set, 8 bpp bytes index the palette from the top. Byte 0xff
    // reads entry 0. The fourth byte is padding and produces no pixel.
    configure(bsu_pkg::FMT_8BPP, 3, 1, 1'b0, 1'b1);
    send_start();
    send_pixel(8'hff);
    send_pixel(8'h00);
    send_pixel(8'h5a);
    send_pixel(8'h5a);

    // This is a bottom-up 24 bpp image with two rows of one pixel each. Every
    // row has one padding byte.
    configure(bsu_pkg::FMT_24BPP, 1, 2, 1'b1, 1'b0);
    send_start();
    send_pixel(8'hff);
    send_pixel(8'h00);
    send_pixel(8'h80);
    send_pixel(8'h3c);
    send_pixel(8'h01);
    send_pixel(8'hfe);
    send_pixel(8'h7f);
    send_pixel(8'hc3);

    // For a wide 1 bpp image, the receiver stalls for a long time while the
    // sender keeps offering bytes.
    configure(bsu_pkg::FMT_1BPP, 64, 2, 1'b0, 1'b0);
    send_start();
    hold_request = 1'b1;
    run_image(16);

    phase_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      phase_no++;
      steady_feed = ($urandom_range(0, 3) == 0);
      if (phase_no % 7 == 3) begin
        fmt = FMT_ALIAS_24;
      end else begin
        case ($urandom_range(0, 2))
          0:       fmt = bsu_pkg::FMT_1BPP;
          1:       fmt = bsu_pkg::FMT_8BPP;
          default: fmt = bsu_pkg::FMT_24BPP;
        endcase
      end
      if (phase_no % 4 == 2) begin
        // Extreme sizes get only a short run of bytes. Out-of-range values
        // clamp to the limits, and a bottom-up height of 4096 reaches the top
        // of the address range.
        case ((phase_no / 4) % 3)
          0:       begin w = 8191; h = 8191; end
          1:       begin w = 0;    h = 0;    end
          default: begin w = 4096; h = 1;    end
        endcase
        configure(fmt, w, h, 1'($urandom), 1'($urandom));
        send_start();
        run_image(24);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 3);
        bpp = (fmt == bsu_pkg::FMT_1BPP) ? 1 : ((fmt == bsu_pkg::FMT_8BPP) ? 8 : 24);
        n_bytes = h * (((w * bpp + 31) / 32) * 4);
        // Most images are complete, some run a little past the end, and a few
        // are cut short.
        if ($urandom_range(0, 5) == 0) n_bytes = $urandom_range(1, n_bytes);
        else n_bytes = n_bytes + $urandom_range(0, 2);
        configure(fmt, w, h, 1'($urandom), 1'($urandom));
        // Without a start item, the old row position continues under the new
        // registers.
        if ($urandom_range(0, 7) != 0) send_start();
        run_image(n_bytes);
      end
    end

    steady_feed = 1'b0;
    wait_idle();
    if (pixels.errors == 0 && pixels.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
